// ===== src/tbpp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpp_pkg: shared types and constants of the token bucket packet policer
// Field widths, register indexes and reset values, protocol constants and the
// state types of the policer sequencer and the credit unit.
// ----------------------------------------------------------------------------
package tbpp_pkg;

    // Field widths
    localparam int TS_W    = 64;  // timestamp / elapsed time
    localparam int LEN_W   = 16;  // frame_len, captured_len, ether_type
    localparam int TOK_W   = 32;  // tokens_per_period
    localparam int CAP_W   = 48;  // bucket_capacity, bucket_level
    localparam int PER_W   = 32;  // refill_period_ns
    localparam int PROD_W  = TOK_W + TS_W;  // full-width tokens * elapsed
    localparam int QUOT_W  = CAP_W + 1;     // credit quotient, beyond this it saturates
    localparam int CNT_W   = $clog2(QUOT_W);

    // Stream payload widths
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOKENS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD   = 2'd2;

    localparam logic [TOK_W-1:0] TOKENS_RESET   = 32'd625000;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 48'd62500000;
    localparam logic [PER_W-1:0] PERIOD_RESET   = 32'd10000000;

    // Packet classification
    localparam logic [LEN_W-1:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [LEN_W-1:0] IPV4_HDR_BYTES = 16'd20;
    localparam logic [LEN_W-1:0] ETHERTYPE_IPV4 = 16'h0800;

    // Verdict codes
    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_CREDIT,
        ST_REFILL,
        ST_CHARGE,
        ST_OUT
    } tbpp_state_t;

    typedef enum logic [2:0] {
        CU_IDLE,
        CU_MUL_LO,
        CU_MUL_HI,
        CU_ADD,
        CU_CHECK,
        CU_DIV,
        CU_DONE
    } cu_state_t;

    typedef struct packed {
        logic done;  // quotient valid this cycle
        logic sat;   // quotient does not fit QUOT_W bits
    } cu_status_t;

endpackage

// ===== src/token_bucket_packet_policer_unit.sv =====
// Sequence: a packet not policed goes from acceptance straight to the output state; a policed
// packet passes the test and charge states first, and with a refill the credit and refill states.
// Throughput: one packet at a time; a new one is accepted once the verdict is registered, after
// any output stall. A refill takes two 32x32 multiplier passes and, unsaturated, the 49-step divider.
// Reset (aresetn, synchronous): bucket level and refill time to zero, registers
// to their defaults, both channels empty.
// ----------------------------------------------------------------------------
// token_bucket_packet_policer_unit: token bucket packet policer
// Classifies each packet, refills the bucket from elapsed time when more than
// one period has passed, and passes or drops the packet against the credit.
// ----------------------------------------------------------------------------
module token_bucket_packet_policer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata from bit 0: timestamp_ns[63:0], frame_len[15:0], captured_len[15:0],
    // ether_type[15:0]
    input  logic [tbpp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata from bit 0: verdict, then zero fill
    output logic [tbpp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [tbpp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbpp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int LEN_LO = tbpp_pkg::TS_W;
    localparam int CAP_LO = LEN_LO + tbpp_pkg::LEN_W;
    localparam int ETH_LO = CAP_LO + tbpp_pkg::LEN_W;

    logic [tbpp_pkg::TOK_W-1:0]  tokens;
    logic [tbpp_pkg::CAP_W-1:0]  capacity;
    logic [tbpp_pkg::PER_W-1:0]  period;

    tbpp_pkg::cu_status_t        cu_status;
    logic [tbpp_pkg::QUOT_W-1:0] cu_quot;
    logic                        cu_start;

    tbpp_pkg::tbpp_state_t       state_reg, state_next;
    logic [tbpp_pkg::TS_W-1:0]   ts_reg, ts_next;
    logic [tbpp_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [tbpp_pkg::TS_W-1:0]   elapsed_reg, elapsed_next;
    logic                        verdict_reg, verdict_next;
    logic [tbpp_pkg::CAP_W-1:0]  level_reg, level_next;
    logic [tbpp_pkg::TS_W-1:0]   last_reg, last_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        m_verdict_reg, m_verdict_next;

    logic [tbpp_pkg::TS_W-1:0]   s_ts;
    logic [tbpp_pkg::LEN_W-1:0]  s_frame_len;
    logic [tbpp_pkg::LEN_W-1:0]  s_captured_len;
    logic [tbpp_pkg::LEN_W-1:0]  s_ether_type;
    logic                        policed;
    logic [tbpp_pkg::CAP_W+1:0]  refill_sum;

    tbpp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tokens    (tokens),
        .capacity  (capacity),
        .period    (period)
    );

    tbpp_credit_unit u_credit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cu_start),
        .tokens  (tokens),
        .elapsed (elapsed_reg),
        .period  (period),
        .status  (cu_status),
        .quot    (cu_quot)
    );

    assign s_ts           = s_tdata[tbpp_pkg::TS_W-1:0];
    assign s_frame_len    = s_tdata[LEN_LO+tbpp_pkg::LEN_W-1:LEN_LO];
    assign s_captured_len = s_tdata[CAP_LO+tbpp_pkg::LEN_W-1:CAP_LO];
    assign s_ether_type   = s_tdata[ETH_LO+tbpp_pkg::LEN_W-1:ETH_LO];

    // the IPv4 length check also covers the Ethernet header check
    assign policed = (s_ether_type == tbpp_pkg::ETHERTYPE_IPV4) &&
                     (s_captured_len >= (tbpp_pkg::ETH_HDR_BYTES + tbpp_pkg::IPV4_HDR_BYTES));

    assign refill_sum = {2'b00, level_reg} + {1'b0, cu_quot};

    assign s_tready = (state_reg == tbpp_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tbpp_pkg::M_TDATA_W-1){1'b0}}, m_verdict_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tbpp_pkg::ST_IDLE;
            level_reg    <= '0;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ts_reg        <= ts_next;
        len_reg       <= len_next;
        elapsed_reg   <= elapsed_next;
        verdict_reg   <= verdict_next;
        m_verdict_reg <= m_verdict_next;
    end

    always_comb begin
        state_next     = state_reg;
        ts_next        = ts_reg;
        len_next       = len_reg;
        elapsed_next   = elapsed_reg;
        verdict_next   = verdict_reg;
        level_next     = level_reg;
        last_next      = last_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_verdict_next = m_verdict_reg;
        cu_start       = 1'b0;

        // retire the output transaction
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            tbpp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ts_next      = s_ts;
                    len_next     = s_frame_len;
                    elapsed_next = s_ts - last_reg;
                    verdict_next = tbpp_pkg::VERDICT_PASS;
                    state_next   = policed ? tbpp_pkg::ST_TEST : tbpp_pkg::ST_OUT;
                end
            end
            tbpp_pkg::ST_TEST: begin
                if (elapsed_reg > {{(tbpp_pkg::TS_W-tbpp_pkg::PER_W){1'b0}}, period}) begin
                    cu_start   = 1'b1;
                    state_next = tbpp_pkg::ST_CREDIT;
                end else begin
                    state_next = tbpp_pkg::ST_CHARGE;
                end
            end
            tbpp_pkg::ST_CREDIT: begin
                if (cu_status.done) begin
                    state_next = tbpp_pkg::ST_REFILL;
                end
            end
            tbpp_pkg::ST_REFILL: begin
                // saturate at capacity, also when capacity fell below the level
                if (cu_status.sat || (refill_sum > {2'b00, capacity})) begin
                    level_next = capacity;
                end else begin
                    level_next = refill_sum[tbpp_pkg::CAP_W-1:0];
                end
                last_next  = ts_reg;
                state_next = tbpp_pkg::ST_CHARGE;
            end
            tbpp_pkg::ST_CHARGE: begin
                if (level_reg < {{(tbpp_pkg::CAP_W-tbpp_pkg::LEN_W){1'b0}}, len_reg}) begin
                    verdict_next = tbpp_pkg::VERDICT_DROP;
                end else begin
                    level_next = level_reg -
                                 {{(tbpp_pkg::CAP_W-tbpp_pkg::LEN_W){1'b0}}, len_reg};
                end
                state_next = tbpp_pkg::ST_OUT;
            end
            tbpp_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_verdict_next = verdict_reg;
                    state_next     = tbpp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbpp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tbpp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tbpp_cfg_regs: policer configuration registers
// Write-only register file for rate, capacity and refill period. A period of
// zero is presented as one.
// ----------------------------------------------------------------------------
module tbpp_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tbpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbpp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic [tbpp_pkg::TOK_W-1:0]      tokens,
    output logic [tbpp_pkg::CAP_W-1:0]      capacity,
    output logic [tbpp_pkg::PER_W-1:0]      period
);

    logic [tbpp_pkg::TOK_W-1:0] tokens_reg;
    logic [tbpp_pkg::CAP_W-1:0] capacity_reg;
    logic [tbpp_pkg::PER_W-1:0] period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tokens_reg   <= tbpp_pkg::TOKENS_RESET;
            capacity_reg <= tbpp_pkg::CAPACITY_RESET;
            period_reg   <= tbpp_pkg::PERIOD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                tbpp_pkg::CFG_IDX_TOKENS: begin
                    tokens_reg <= cfg_wdata[tbpp_pkg::TOK_W-1:0];
                end
                tbpp_pkg::CFG_IDX_CAPACITY: begin
                    capacity_reg <= cfg_wdata[tbpp_pkg::CAP_W-1:0];
                end
                tbpp_pkg::CFG_IDX_PERIOD: begin
                    period_reg <= cfg_wdata[tbpp_pkg::PER_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign tokens   = tokens_reg;
    assign capacity = capacity_reg;
    assign period   = (period_reg == '0) ? tbpp_pkg::PER_W'(1) : period_reg;

endmodule

// ===== src/tbpp_credit_unit.sv =====
// ----------------------------------------------------------------------------
// tbpp_credit_unit: iterative credit generator
// Computes floor(tokens * elapsed / period) with one shared 32x32 multiplier
// used twice and a restoring divider that retires one quotient bit a cycle.
// Quotients of 2^49 or more are flagged as saturated.
// ----------------------------------------------------------------------------
module tbpp_credit_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tbpp_pkg::TOK_W-1:0]    tokens,
    input  logic [tbpp_pkg::TS_W-1:0]     elapsed,
    input  logic [tbpp_pkg::PER_W-1:0]    period,
    output tbpp_pkg::cu_status_t          status,
    output logic [tbpp_pkg::QUOT_W-1:0]   quot
);

    localparam int HI_W = tbpp_pkg::PROD_W - tbpp_pkg::QUOT_W;

    tbpp_pkg::cu_state_t state_reg, state_next;

    logic [2*tbpp_pkg::TOK_W-1:0]  part_reg, part_next;
    logic [tbpp_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [tbpp_pkg::PER_W-1:0]    rem_reg, rem_next;
    logic [tbpp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          sat_reg, sat_next;

    logic [tbpp_pkg::TOK_W-1:0]    mul_b;
    logic [2*tbpp_pkg::TOK_W-1:0]  mul_out;
    logic [tbpp_pkg::PER_W:0]      trial;
    logic [tbpp_pkg::PER_W:0]      diff;
    logic                          take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbpp_pkg::CU_IDLE;
        end else begin
            state_reg <= state_next;
        end
        part_reg <= part_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
    end

    always_comb begin
        // the one multiplier: low half of elapsed first, then the high half
        mul_b   = (state_reg == tbpp_pkg::CU_MUL_LO) ? elapsed[tbpp_pkg::TOK_W-1:0]
                                                     : elapsed[tbpp_pkg::TS_W-1:tbpp_pkg::TOK_W];
        mul_out = tokens * mul_b;

        // restoring division step: bring in the next dividend bit
        trial = {rem_reg, prod_reg[tbpp_pkg::QUOT_W-1]};
        take  = (trial >= {1'b0, period});
        diff  = trial - {1'b0, period};

        state_next = state_reg;
        part_next  = part_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;

        case (state_reg)
            tbpp_pkg::CU_IDLE: begin
                if (start) begin
                    state_next = tbpp_pkg::CU_MUL_LO;
                end
            end
            tbpp_pkg::CU_MUL_LO: begin
                part_next  = mul_out;
                state_next = tbpp_pkg::CU_MUL_HI;
            end
            tbpp_pkg::CU_MUL_HI: begin
                prod_next  = {{tbpp_pkg::TOK_W{1'b0}}, part_reg};
                part_next  = mul_out;
                state_next = tbpp_pkg::CU_ADD;
            end
            tbpp_pkg::CU_ADD: begin
                prod_next  = prod_reg + {part_reg, {tbpp_pkg::TOK_W{1'b0}}};
                state_next = tbpp_pkg::CU_CHECK;
            end
            tbpp_pkg::CU_CHECK: begin
                // quotient overflows QUOT_W bits when the upper part reaches the divisor
                sat_next = (prod_reg[tbpp_pkg::PROD_W-1:tbpp_pkg::QUOT_W] >=
                            HI_W'(period));
                rem_next = prod_reg[tbpp_pkg::QUOT_W+tbpp_pkg::PER_W-1:tbpp_pkg::QUOT_W];
                cnt_next = tbpp_pkg::CNT_W'(tbpp_pkg::QUOT_W - 1);
                state_next = sat_next ? tbpp_pkg::CU_DONE : tbpp_pkg::CU_DIV;
            end
            tbpp_pkg::CU_DIV: begin
                rem_next = take ? diff[tbpp_pkg::PER_W-1:0] : trial[tbpp_pkg::PER_W-1:0];
                // shift dividend bits out of the low part, quotient bits in
                prod_next = {prod_reg[tbpp_pkg::PROD_W-1:tbpp_pkg::QUOT_W],
                             prod_reg[tbpp_pkg::QUOT_W-2:0], take};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = tbpp_pkg::CU_DONE;
                end
            end
            tbpp_pkg::CU_DONE: begin
                state_next = tbpp_pkg::CU_IDLE;
            end
            default: begin
                state_next = tbpp_pkg::CU_IDLE;
            end
        endcase
    end

    assign status.done = (state_reg == tbpp_pkg::CU_DONE);
    assign status.sat  = sat_reg;
    assign quot        = prod_reg[tbpp_pkg::QUOT_W-1:0];

endmodule
